// ----- hdl/kvm_pkg.sv -----
package kvm_pkg;

    localparam int MAX_FRAMES   = 256;
    localparam int VSTORE_DEPTH = 16384;
    localparam int MAX_VPF      = 2048;
    localparam int NORMAL_COUNT = 162;
    localparam int PARAM_COUNT  = 6;

    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int VADDR_W = $clog2(VSTORE_DEPTH);
    localparam int FC_W    = 9;
    localparam int VPF_W   = 12;
    localparam int LADDR_W = 8 + VPF_W;
    localparam int NIDX_W  = $clog2(NORMAL_COUNT);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;

    localparam int BLEND_ONE = 65536;
    localparam int NORM_ONE  = 16384;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTS_PER_FRAME = 2'd1;

    localparam logic [1:0] MODE_PARAM  = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_PARAM,
        OP_VERTEX,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         frame_a;
        logic [7:0]         frame_b;
        logic [10:0]        vertex_index;
        logic [2:0]         param_select;
        logic signed [31:0] param_value;
        logic [7:0]         byte_x;
        logic [7:0]         byte_y;
        logic [7:0]         byte_z;
        logic [7:0]         normal_code;
        logic [16:0]        blend;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } out_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         frame_a;
        logic [7:0]         frame_b;
        logic [2:0]         sel;
        logic [VADDR_W-1:0] addr_a;
        logic [VADDR_W-1:0] addr_b;
        logic               oob_a;
        logic               oob_b;
        logic [31:0]        data;
        logic [16:0]        blend;
    } cmd_t;

    localparam logic signed [15:0] K0 = 16'sd0;
    localparam logic signed [15:0] KA = 16'sd8614;
    localparam logic signed [15:0] KB = 16'sd13937;
    localparam logic signed [15:0] KC = 16'sd7256;
    localparam logic signed [15:0] KD = 16'sd3913;
    localparam logic signed [15:0] KE = 16'sd14159;
    localparam logic signed [15:0] KF = 16'sd4837;
    localparam logic signed [15:0] KG = 16'sd15654;
    localparam logic signed [15:0] KH = 16'sd5063;
    localparam logic signed [15:0] KI = 16'sd8192;
    localparam logic signed [15:0] KJ = 16'sd13255;
    localparam logic signed [15:0] KK = 16'sd2662;
    localparam logic signed [15:0] KL = 16'sd4307;
    localparam logic signed [15:0] KM = 16'sd15582;
    localparam logic signed [15:0] KN = 16'sd2419;
    localparam logic signed [15:0] KO = 16'sd11740;
    localparam logic signed [15:0] KP = 16'sd11169;
    localparam logic signed [15:0] KQ = 16'sd9630;
    localparam logic signed [15:0] KR = 16'sd6969;
    localparam logic signed [15:0] KS = 16'sd11275;
    localparam logic signed [15:0] KU = 16'sd16384;

    // unit normals, Q2.14, packed {x, y, z}
    localparam logic [47:0] NORMAL_ROM [NORMAL_COUNT] = '{
        {-KA,K0,KB},{-KC,KD,KE},{-KF,K0,KG},{-KH,KI,KJ},{-KK,KL,KM},{K0,K0,KU},
        {K0,KB,KA},{-KN,KO,KP},{KN,KO,KP},{K0,KA,KB},{KH,KI,KJ},{KA,K0,KB},
        {KF,K0,KG},{KC,KD,KE},{KK,KL,KM},{-KP,KN,KO},{-KJ,KH,KI},{-KQ,KR,KS},
        {-KB,KA,K0},{-KE,KC,KD},{-KO,KP,KN},{-KS,KQ,KR},{-KI,KJ,KH},{-KD,KE,KC},
        {-KR,KS,KQ},{-KO,KP,-KN},{-KI,KJ,-KH},{-KA,KB,K0},{K0,KB,-KA},{-KD,KE,-KC},
        {K0,KG,-KF},{-KL,KM,-KK},{K0,KU,K0},{K0,KG,KF},{-KL,KM,KK},{KD,KE,KC},
        {KL,KM,KK},{KI,KJ,KH},{KD,KE,-KC},{KL,KM,-KK},{KI,KJ,-KH},{KB,KA,K0},
        {KO,KP,KN},{KO,KP,-KN},{KA,KB,K0},{KR,KS,KQ},{KE,KC,KD},{KS,KQ,KR},
        {KJ,KH,KI},{KP,KN,KO},{KQ,KR,KS},{KG,KF,K0},{KU,K0,K0},{KM,KK,KL},
        {KB,-KA,K0},{KG,-KF,K0},{KE,-KC,KD},{KM,-KK,KL},{KJ,-KH,KI},{KP,-KN,KO},
        {KB,K0,KA},{KE,KC,-KD},{KJ,KH,-KI},{KM,KK,-KL},{KA,K0,-KB},{KP,KN,-KO},
        {KP,-KN,-KO},{KB,K0,-KA},{KJ,-KH,-KI},{KE,-KC,-KD},{KM,-KK,-KL},{KN,KO,-KP},
        {KH,KI,-KJ},{KR,KS,-KQ},{KC,KD,-KE},{KQ,KR,-KS},{KS,KQ,-KR},{-KN,KO,-KP},
        {-KH,KI,-KJ},{K0,KA,-KB},{-KA,K0,-KB},{-KC,KD,-KE},{-KF,K0,-KG},{-KK,KL,-KM},
        {K0,K0,-KU},{KF,K0,-KG},{KK,KL,-KM},{-KC,-KD,-KE},{-KH,-KI,-KJ},{-KK,-KL,-KM},
        {K0,-KB,-KA},{-KN,-KO,-KP},{KN,-KO,-KP},{K0,-KA,-KB},{KH,-KI,-KJ},{KC,-KD,-KE},
        {KK,-KL,-KM},{KD,-KE,-KC},{KI,-KJ,-KH},{KR,-KS,-KQ},{KO,-KP,-KN},{KS,-KQ,-KR},
        {KQ,-KR,-KS},{K0,-KG,-KF},{K0,-KU,K0},{KL,-KM,-KK},{K0,-KB,KA},{K0,-KG,KF},
        {KD,-KE,KC},{KL,-KM,KK},{KI,-KJ,KH},{KO,-KP,KN},{KA,-KB,K0},{-KD,-KE,-KC},
        {-KI,-KJ,-KH},{-KL,-KM,-KK},{-KB,-KA,K0},{-KO,-KP,-KN},{-KO,-KP,KN},{-KA,-KB,K0},
        {-KI,-KJ,KH},{-KD,-KE,KC},{-KL,-KM,KK},{-KE,-KC,KD},{-KJ,-KH,KI},{-KS,-KQ,KR},
        {-KP,-KN,KO},{-KC,-KD,KE},{-KQ,-KR,KS},{-KH,-KI,KJ},{-KN,-KO,KP},{-KR,-KS,KQ},
        {-KK,-KL,KM},{KC,-KD,KE},{KK,-KL,KM},{KH,-KI,KJ},{KN,-KO,KP},{K0,-KA,KB},
        {KR,-KS,KQ},{KQ,-KR,KS},{KS,-KQ,KR},{-KG,KF,K0},{-KM,KK,KL},{-KU,K0,K0},
        {-KB,K0,KA},{-KG,-KF,K0},{-KM,-KK,KL},{-KE,KC,-KD},{-KM,KK,-KL},{-KJ,KH,-KI},
        {-KE,-KC,-KD},{-KM,-KK,-KL},{-KJ,-KH,-KI},{-KP,KN,-KO},{-KP,-KN,-KO},{-KB,K0,-KA},
        {-KS,KQ,-KR},{-KQ,KR,-KS},{-KR,KS,-KQ},{-KR,-KS,-KQ},{-KQ,-KR,-KS},{-KS,-KQ,-KR}
    };

endpackage

// ----- hdl/kvm_front.sv -----
module kvm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               full,
    input  kvm_pkg::in_t                       item,
    input  logic                               cfg_valid,
    input  logic [kvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kvm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               cmd_valid,
    output kvm_pkg::cmd_t                      cmd
);

    logic [kvm_pkg::FC_W-1:0]    frame_count_reg;
    logic [kvm_pkg::VPF_W-1:0]   verts_reg;
    logic [kvm_pkg::FC_W-1:0]    nf;
    logic [kvm_pkg::VPF_W-1:0]   nv;
    logic [7:0]                  fr_a;
    logic [7:0]                  fr_b;
    logic [7:0]                  row_a;
    logic                        vi_hi;
    logic                        is_query;
    logic [10:0]                 vi_sel;
    logic [kvm_pkg::LADDR_W-1:0] lin_a;
    logic [kvm_pkg::LADDR_W-1:0] lin_b;
    logic                        oob_a;
    logic                        oob_b;
    logic                        ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= kvm_pkg::FC_W'(1);
            verts_reg       <= kvm_pkg::VPF_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kvm_pkg::CFG_FRAME_COUNT:     frame_count_reg <= cfg_data[kvm_pkg::FC_W-1:0];
                kvm_pkg::CFG_VERTS_PER_FRAME: verts_reg       <= cfg_data[kvm_pkg::VPF_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_count_reg == '0)
            nf = kvm_pkg::FC_W'(1);
        else if (frame_count_reg > kvm_pkg::FC_W'(kvm_pkg::MAX_FRAMES))
            nf = kvm_pkg::FC_W'(kvm_pkg::MAX_FRAMES);
        else
            nf = frame_count_reg;
        if (verts_reg == '0)
            nv = kvm_pkg::VPF_W'(1);
        else if (verts_reg > kvm_pkg::VPF_W'(kvm_pkg::MAX_VPF))
            nv = kvm_pkg::VPF_W'(kvm_pkg::MAX_VPF);
        else
            nv = verts_reg;
    end

    assign fr_a     = ({1'b0, item.frame_a} >= nf) ? 8'(nf - 1'b1) : item.frame_a;
    assign fr_b     = ({1'b0, item.frame_b} >= nf) ? 8'(nf - 1'b1) : item.frame_b;
    assign vi_hi    = {1'b0, item.vertex_index} >= nv;
    assign is_query = item.mode == kvm_pkg::MODE_QUERY;
    assign row_a    = is_query ? fr_a : item.frame_a;
    assign vi_sel   = (is_query && vi_hi) ? '0 : item.vertex_index;
    assign lin_a    = kvm_pkg::LADDR_W'(row_a) * kvm_pkg::LADDR_W'(nv)
                    + kvm_pkg::LADDR_W'(vi_sel);
    assign lin_b    = kvm_pkg::LADDR_W'(fr_b) * kvm_pkg::LADDR_W'(nv)
                    + kvm_pkg::LADDR_W'(vi_sel);
    assign oob_a    = lin_a >= kvm_pkg::LADDR_W'(kvm_pkg::VSTORE_DEPTH);
    assign oob_b    = lin_b >= kvm_pkg::LADDR_W'(kvm_pkg::VSTORE_DEPTH);

    always_comb
    begin
        cmd.frame_a = row_a;
        cmd.frame_b = fr_b;
        cmd.sel     = item.param_select;
        cmd.addr_a  = kvm_pkg::VADDR_W'(lin_a);
        cmd.addr_b  = kvm_pkg::VADDR_W'(lin_b);
        cmd.oob_a   = oob_a;
        cmd.oob_b   = oob_b;
        cmd.blend   = (item.blend > 17'(kvm_pkg::BLEND_ONE)) ? 17'(kvm_pkg::BLEND_ONE)
                                                              : item.blend;
        case (item.mode)
            kvm_pkg::MODE_PARAM:
            begin
                cmd.op   = kvm_pkg::OP_PARAM;
                cmd.data = item.param_value;
                ok       = item.param_select < 3'(kvm_pkg::PARAM_COUNT);
            end
            kvm_pkg::MODE_VERTEX:
            begin
                cmd.op   = kvm_pkg::OP_VERTEX;
                cmd.data = {item.normal_code, item.byte_z, item.byte_y, item.byte_x};
                ok       = !vi_hi && !oob_a;
            end
            kvm_pkg::MODE_QUERY:
            begin
                cmd.op   = kvm_pkg::OP_QUERY;
                cmd.data = item.param_value;
                ok       = 1'b1;
            end
            default:
            begin
                cmd.op   = kvm_pkg::OP_QUERY;
                cmd.data = item.param_value;
                ok       = 1'b0;
            end
        endcase
    end

    assign cmd_valid = push && !full && ok;

endmodule

// ----- hdl/kvm_queue.sv -----
module kvm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  kvm_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output kvm_pkg::cmd_t rd_data,
    output logic          empty
);

    kvm_pkg::cmd_t                q_mem_reg [kvm_pkg::QUEUE_DEPTH];
    logic [kvm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [kvm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [kvm_pkg::QCNT_W-1:0]   cnt_reg;
    logic [kvm_pkg::QCNT_W-1:0]   cnt_next;

    assign full    = cnt_reg == kvm_pkg::QCNT_W'(kvm_pkg::QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !(rd_en && !empty))
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en && !empty)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hdl/kvm_back.sv -----
module kvm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  kvm_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output kvm_pkg::out_t result,
    output logic          empty,
    input  logic          pop
);

    localparam int SQ = kvm_pkg::SQRT_STEPS;
    localparam int DV = kvm_pkg::DIV_STEPS;

    logic adv;

    // stage A: memory read data
    logic [31:0]        vtx_mem [kvm_pkg::VSTORE_DEPTH];
    logic [31:0]        vtx_a_reg;
    logic [31:0]        vtx_b_reg;
    logic [31:0]        prm_a_reg [kvm_pkg::PARAM_COUNT];
    logic [31:0]        prm_b_reg [kvm_pkg::PARAM_COUNT];
    logic               a_vld_reg;
    logic               a_oob_a_reg;
    logic               a_oob_b_reg;
    logic [16:0]        a_t_reg;

    // stage B: per-frame positions and ROM normals
    logic [31:0]        word_a;
    logic [31:0]        word_b;
    logic [7:0]         nidx_a;
    logic [7:0]         nidx_b;
    logic [47:0]        rom_a;
    logic [47:0]        rom_b;
    logic               b_vld_reg;
    logic [16:0]        b_t_reg;
    logic signed [41:0] b_p0_reg [3];
    logic signed [41:0] b_p1_reg [3];
    logic signed [15:0] b_na_reg [3];
    logic signed [15:0] b_nb_reg [3];

    // stage C: position difference, blended normal
    logic               c_vld_reg;
    logic [16:0]        c_t_reg;
    logic signed [42:0] c_d_reg [3];
    logic signed [41:0] c_p0_reg [3];
    logic signed [31:0] c_v_reg [3];
    logic signed [42:0] c_d_next [3];
    logic signed [31:0] c_v_next [3];

    // stage D: split products, squares
    logic               d_vld_reg;
    logic [38:0]        d_lo_reg [3];
    logic signed [38:0] d_hi_reg [3];
    logic signed [41:0] d_p0_reg [3];
    logic [30:0]        d_mag_reg [3];
    logic [2:0]         d_neg_reg;
    logic [61:0]        d_sq_reg [3];
    logic [30:0]        d_mag_next [3];

    // stage E: full blend products, square sum
    logic               e_vld_reg;
    logic signed [61:0] e_prod_reg [3];
    logic signed [41:0] e_p0_reg [3];
    logic [61:0]        e_sum_reg;
    logic [30:0]        e_mag_reg [3];
    logic [2:0]         e_neg_reg;

    // stage F and square root steps
    logic [31:0]        f_pos_next [3];
    logic               sq_vld_reg [SQ+1];
    logic [61:0]        sq_rem_reg [SQ+1];
    logic [30:0]        sq_root_reg [SQ+1];
    logic [31:0]        sq_pos_reg [SQ+1][3];
    logic [30:0]        sq_mag_reg [SQ+1][3];
    logic [2:0]         sq_neg_reg [SQ+1];

    // division steps
    logic               dv_vld_reg [DV+1];
    logic [30:0]        dv_len_reg [DV+1];
    logic               dv_zero_reg [DV+1];
    logic [45:0]        dv_rem_reg [DV+1][3];
    logic [14:0]        dv_q_reg [DV+1][3];
    logic [31:0]        dv_pos_reg [DV+1][3];
    logic [2:0]         dv_neg_reg [DV+1];

    // output buffer
    kvm_pkg::out_t      ob_mem_reg [2];
    logic               ob_wr_reg;
    logic               ob_rd_reg;
    logic [1:0]         ob_cnt_reg;
    logic               ob_push;
    logic               ob_pop;
    kvm_pkg::out_t      res_next;
    logic [15:0]        norm_next [3];

    function automatic logic signed [41:0] frame_pos(input logic [31:0] sc,
                                                     input logic [31:0] tr,
                                                     input logic [7:0]  b);
        logic signed [40:0] m;
        m = $signed(sc) * $signed({1'b0, b});
        return 42'(m) + 42'($signed(tr));
    endfunction

    assign adv     = !(dv_vld_reg[DV] && ob_cnt_reg == 2'd2);
    assign cmd_pop = adv && !cmd_empty;

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.op == kvm_pkg::OP_VERTEX)
            vtx_mem[cmd.addr_a] <= cmd.data;
        if (adv)
        begin
            vtx_a_reg <= vtx_mem[cmd.addr_a];
            vtx_b_reg <= vtx_mem[cmd.addr_b];
        end
    end

    for (genvar s = 0; s < kvm_pkg::PARAM_COUNT; s++)
    begin : g_prm
        logic [31:0] prm_mem [kvm_pkg::MAX_FRAMES];
        always_ff @(posedge clk)
        begin
            if (cmd_pop && cmd.op == kvm_pkg::OP_PARAM && cmd.sel == 3'(s))
                prm_mem[cmd.frame_a] <= cmd.data;
            if (adv)
            begin
                prm_a_reg[s] <= prm_mem[cmd.frame_a];
                prm_b_reg[s] <= prm_mem[cmd.frame_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_oob_a_reg <= cmd.oob_a;
            a_oob_b_reg <= cmd.oob_b;
            a_t_reg     <= cmd.blend;
        end
    end

    // ---------------- stage B ----------------
    assign word_a = a_oob_a_reg ? '0 : vtx_a_reg;
    assign word_b = a_oob_b_reg ? '0 : vtx_b_reg;
    assign nidx_a = (word_a[31:24] >= 8'(kvm_pkg::NORMAL_COUNT))
                  ? word_a[31:24] - 8'(kvm_pkg::NORMAL_COUNT) : word_a[31:24];
    assign nidx_b = (word_b[31:24] >= 8'(kvm_pkg::NORMAL_COUNT))
                  ? word_b[31:24] - 8'(kvm_pkg::NORMAL_COUNT) : word_b[31:24];
    assign rom_a  = kvm_pkg::NORMAL_ROM[kvm_pkg::NIDX_W'(nidx_a)];
    assign rom_b  = kvm_pkg::NORMAL_ROM[kvm_pkg::NIDX_W'(nidx_b)];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_t_reg <= a_t_reg;
            for (int c = 0; c < 3; c++)
            begin
                b_p0_reg[c] <= frame_pos(prm_a_reg[c], prm_a_reg[c+3], word_a[8*c +: 8]);
                b_p1_reg[c] <= frame_pos(prm_b_reg[c], prm_b_reg[c+3], word_b[8*c +: 8]);
                b_na_reg[c] <= rom_a[47-16*c -: 16];
                b_nb_reg[c] <= rom_b[47-16*c -: 16];
            end
        end
    end

    // ---------------- stage C ----------------
    always_comb
    begin
        logic signed [16:0] nd;
        logic signed [34:0] np;
        for (int c = 0; c < 3; c++)
        begin
            c_d_next[c] = 43'(b_p1_reg[c]) - 43'(b_p0_reg[c]);
            nd          = 17'(b_nb_reg[c]) - 17'(b_na_reg[c]);
            np          = nd * $signed({1'b0, b_t_reg});
            c_v_next[c] = 32'((36'(b_na_reg[c]) <<< 16) + 36'(np));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_t_reg <= b_t_reg;
            for (int c = 0; c < 3; c++)
            begin
                c_d_reg[c]  <= c_d_next[c];
                c_p0_reg[c] <= b_p0_reg[c];
                c_v_reg[c]  <= c_v_next[c];
            end
        end
    end

    // ---------------- stage D ----------------
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            d_mag_next[c] = c_v_reg[c][31] ? 31'(-c_v_reg[c]) : 31'(c_v_reg[c]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d_lo_reg[c]  <= 39'(c_d_reg[c][21:0]) * 39'(c_t_reg);
                d_hi_reg[c]  <= $signed(c_d_reg[c][42:22]) * $signed({1'b0, c_t_reg});
                d_p0_reg[c]  <= c_p0_reg[c];
                d_mag_reg[c] <= d_mag_next[c];
                d_neg_reg[c] <= c_v_reg[c][31];
                d_sq_reg[c]  <= 62'(d_mag_next[c]) * 62'(d_mag_next[c]);
            end
        end
    end

    // ---------------- stage E ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e_prod_reg[c] <= (62'(d_hi_reg[c]) <<< 22) + 62'(d_lo_reg[c]);
                e_p0_reg[c]   <= d_p0_reg[c];
                e_mag_reg[c]  <= d_mag_reg[c];
            end
            e_neg_reg <= d_neg_reg;
            e_sum_reg <= d_sq_reg[0] + d_sq_reg[1] + d_sq_reg[2];
        end
    end

    // ---------------- stage F: round and saturate ----------------
    always_comb
    begin
        logic signed [61:0] acc;
        logic signed [61:0] r;
        for (int c = 0; c < 3; c++)
        begin
            acc = (62'(e_p0_reg[c]) <<< 16) + e_prod_reg[c] + 62'sd32768;
            r   = acc >>> 16;
            if (r > 62'sd2147483647)
                f_pos_next[c] = 32'h7fff_ffff;
            else if (r < -62'sd2147483648)
                f_pos_next[c] = 32'h8000_0000;
            else
                f_pos_next[c] = 32'(r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= e_sum_reg;
            sq_root_reg[0] <= '0;
            sq_pos_reg[0]  <= f_pos_next;
            sq_mag_reg[0]  <= e_mag_reg;
            sq_neg_reg[0]  <= e_neg_reg;
        end
    end

    // ---------------- square root, one bit per step ----------------
    for (genvar j = 0; j < SQ; j++)
    begin : g_sqrt
        localparam int BIT = SQ - 1 - j;
        logic [63:0] term;
        logic        ge;
        assign term = (64'(sq_root_reg[j]) << (BIT + 1)) + (64'(1) << (2 * BIT));
        assign ge   = 64'(sq_rem_reg[j]) >= term;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j+1]  <= ge ? 62'(64'(sq_rem_reg[j]) - term) : sq_rem_reg[j];
                sq_root_reg[j+1] <= ge ? (sq_root_reg[j] | (31'(1) << BIT)) : sq_root_reg[j];
                sq_pos_reg[j+1]  <= sq_pos_reg[j];
                sq_mag_reg[j+1]  <= sq_mag_reg[j];
                sq_neg_reg[j+1]  <= sq_neg_reg[j];
            end
        end
    end

    // ---------------- division setup ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_len_reg[0]  <= sq_root_reg[SQ];
            dv_zero_reg[0] <= sq_root_reg[SQ] == '0;
            dv_pos_reg[0]  <= sq_pos_reg[SQ];
            dv_neg_reg[0]  <= sq_neg_reg[SQ];
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= (46'(sq_mag_reg[SQ][c]) << 14) + 46'(sq_root_reg[SQ] >> 1);
                dv_q_reg[0][c]   <= '0;
            end
        end
    end

    // ---------------- restoring division, one quotient bit per step ----------------
    for (genvar j = 0; j < DV; j++)
    begin : g_div
        localparam int BIT = DV - 1 - j;
        logic [45:0] dsub;
        assign dsub = 46'(dv_len_reg[j]) << BIT;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                dv_pos_reg[j+1]  <= dv_pos_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                for (int c = 0; c < 3; c++)
                begin
                    if (dv_rem_reg[j][c] >= dsub)
                    begin
                        dv_rem_reg[j+1][c] <= dv_rem_reg[j][c] - dsub;
                        dv_q_reg[j+1][c]   <= dv_q_reg[j][c] | (15'(1) << BIT);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][c] <= dv_rem_reg[j][c];
                        dv_q_reg[j+1][c]   <= dv_q_reg[j][c];
                    end
                end
            end
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            for (int j = 0; j <= SQ; j++)
                sq_vld_reg[j] <= 1'b0;
            for (int j = 0; j <= DV; j++)
                dv_vld_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg     <= cmd_pop && cmd.op == kvm_pkg::OP_QUERY;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            sq_vld_reg[0] <= e_vld_reg;
            for (int j = 0; j < SQ; j++)
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            dv_vld_reg[0] <= sq_vld_reg[SQ];
            for (int j = 0; j < DV; j++)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end
    end

    // ---------------- final normal and output buffer ----------------
    always_comb
    begin
        logic [14:0] qc;
        for (int c = 0; c < 3; c++)
        begin
            qc = (dv_q_reg[DV][c] > 15'(kvm_pkg::NORM_ONE)) ? 15'(kvm_pkg::NORM_ONE)
                                                            : dv_q_reg[DV][c];
            if (dv_zero_reg[DV])
                norm_next[c] = '0;
            else if (dv_neg_reg[DV][c])
                norm_next[c] = -16'(qc);
            else
                norm_next[c] = 16'(qc);
        end
        res_next.pos_x  = dv_pos_reg[DV][0];
        res_next.pos_y  = dv_pos_reg[DV][1];
        res_next.pos_z  = dv_pos_reg[DV][2];
        res_next.norm_x = norm_next[0];
        res_next.norm_y = norm_next[1];
        res_next.norm_z = norm_next[2];
    end

    assign ob_push = adv && dv_vld_reg[DV];
    assign ob_pop  = pop && !empty;
    assign empty   = ob_cnt_reg == 2'd0;
    assign result  = ob_mem_reg[ob_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            if (ob_push)
                ob_wr_reg <= !ob_wr_reg;
            if (ob_pop)
                ob_rd_reg <= !ob_rd_reg;
            if (ob_push && !ob_pop)
                ob_cnt_reg <= ob_cnt_reg + 1'b1;
            else if (!ob_push && ob_pop)
                ob_cnt_reg <= ob_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_push)
            ob_mem_reg[ob_wr_reg] <= res_next;
    end

endmodule

// ----- hdl/keyframe_vertex_morph_core.sv -----
// A query gives a result on the result side; loads give no result.
// Throughput: one item per cycle; the arithmetic pipeline (one square-root bit and one
// quotient bit per stage) stalls only while the two-entry result buffer is full.
// Reset (rst_n, asynchronous, active low) empties the queues and pipeline and sets both
// configuration registers to 1; parameter and vertex memories hold nothing until loaded.
module keyframe_vertex_morph_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  kvm_pkg::in_t                      item,
    output logic                              empty,
    input  logic                              pop,
    output kvm_pkg::out_t                     result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kvm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic          cmd_valid;
    kvm_pkg::cmd_t cmd_in;
    kvm_pkg::cmd_t cmd_out;
    logic          cmd_empty;
    logic          cmd_pop;

    assign cfg_ready = 1'b1;

    kvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    kvm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    kvm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 3000;

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    kvm_pkg::in_t  item;
    logic          empty;
    logic          pop;
    kvm_pkg::out_t result;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [kvm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kvm_pkg::CFG_DATA_W-1:0] cfg_data;

    keyframe_vertex_morph_core uut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    class morph_scoreboard;
        kvm_pkg::out_t pending[$];
        int   errors;
        int   matched;

        function new();
            errors = 0;
            matched = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void note(kvm_pkg::out_t x);
            pending.push_back(x);
        endfunction

        task check(kvm_pkg::out_t got);
            kvm_pkg::out_t e;
            if (pending.size() == 0)
            begin
                report("result with no query outstanding");
                return;
            end
            e = pending.pop_front();
            matched++;
            if (got.pos_x !== e.pos_x)
                report($sformatf("pos_x got %0d want %0d", got.pos_x, e.pos_x));
            if (got.pos_y !== e.pos_y)
                report($sformatf("pos_y got %0d want %0d", got.pos_y, e.pos_y));
            if (got.pos_z !== e.pos_z)
                report($sformatf("pos_z got %0d want %0d", got.pos_z, e.pos_z));
            if (got.norm_x !== e.norm_x)
                report($sformatf("norm_x got %0d want %0d", got.norm_x, e.norm_x));
            if (got.norm_y !== e.norm_y)
                report($sformatf("norm_y got %0d want %0d", got.norm_y, e.norm_y));
            if (got.norm_z !== e.norm_z)
                report($sformatf("norm_z got %0d want %0d", got.norm_z, e.norm_z));
        endtask
    endclass

    morph_scoreboard sb;

    // mirror of the block state
    logic [31:0] frame_tab [kvm_pkg::MAX_FRAMES*kvm_pkg::PARAM_COUNT];
    bit          frame_tab_set [kvm_pkg::MAX_FRAMES*kvm_pkg::PARAM_COUNT];
    logic [31:0] vert_mem [kvm_pkg::VSTORE_DEPTH];
    bit          vert_mem_set [kvm_pkg::VSTORE_DEPTH];
    logic [8:0]  frame_count_r;
    logic [11:0] verts_per_frame_r;

    int n_queries;
    int n_loads;
    int n_phases;
    int hold_request;

    function automatic int live_frames();
        if (frame_count_r == 0) return 1;
        if (frame_count_r > kvm_pkg::MAX_FRAMES) return kvm_pkg::MAX_FRAMES;
        return int'(frame_count_r);
    endfunction

    function automatic int live_verts();
        if (verts_per_frame_r == 0) return 1;
        if (verts_per_frame_r > kvm_pkg::MAX_VPF) return kvm_pkg::MAX_VPF;
        return int'(verts_per_frame_r);
    endfunction

    function automatic bit morph_predict(kvm_pkg::in_t it, output kvm_pkg::out_t r);
        int nv;
        int nf;
        int fr [2];
        int vi;
        int addr;
        int ia;
        int ib;
        longint t;
        longint p [2];
        longint acc;
        longint b;
        longint sc;
        longint tr;
        longint na;
        longint nb;
        longint v [3];
        longint pos [3];
        longint n [3];
        longint unsigned sum;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned mag;
        longint unsigned q;
        logic [31:0] w [2];
        logic [47:0] ea;
        logic [47:0] eb;
        nv = live_verts();
        r = '0;
        if (it.mode == kvm_pkg::MODE_PARAM)
        begin
            if (it.param_select <= 5)
            begin
                frame_tab[it.frame_a*kvm_pkg::PARAM_COUNT + it.param_select] = it.param_value;
                frame_tab_set[it.frame_a*kvm_pkg::PARAM_COUNT + it.param_select] = 1;
            end
            return 0;
        end
        if (it.mode == kvm_pkg::MODE_VERTEX)
        begin
            addr = it.frame_a * nv + it.vertex_index;
            if (it.vertex_index < nv && addr < kvm_pkg::VSTORE_DEPTH)
            begin
                vert_mem[addr] = {it.normal_code, it.byte_z, it.byte_y, it.byte_x};
                vert_mem_set[addr] = 1;
            end
            return 0;
        end
        if (it.mode != kvm_pkg::MODE_QUERY) return 0;

        t = longint'(it.blend);
        if (t > kvm_pkg::BLEND_ONE) t = kvm_pkg::BLEND_ONE;
        nf = live_frames();
        fr[0] = (it.frame_a >= nf) ? nf - 1 : int'(it.frame_a);
        fr[1] = (it.frame_b >= nf) ? nf - 1 : int'(it.frame_b);
        vi = (it.vertex_index >= nv) ? 0 : int'(it.vertex_index);
        for (int k = 0; k < 2; k++)
        begin
            addr = fr[k] * nv + vi;
            w[k] = (addr < kvm_pkg::VSTORE_DEPTH) ? vert_mem[addr] : 32'd0;
        end
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                b  = longint'((w[k] >> (8*c)) & 32'hFF);
                sc = longint'($signed(frame_tab[fr[k]*kvm_pkg::PARAM_COUNT + c]));
                tr = longint'($signed(frame_tab[fr[k]*kvm_pkg::PARAM_COUNT + 3 + c]));
                p[k] = sc * b + tr;
            end
            acc = (p[0] * 65536 + (p[1] - p[0]) * t + 32768) >>> 16;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            pos[c] = acc;
        end

        ia = int'(w[0][31:24]) % kvm_pkg::NORMAL_COUNT;
        ib = int'(w[1][31:24]) % kvm_pkg::NORMAL_COUNT;
        ea = kvm_pkg::NORMAL_ROM[ia];
        eb = kvm_pkg::NORMAL_ROM[ib];
        sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            na = longint'($signed(ea[47-16*c -: 16]));
            nb = longint'($signed(eb[47-16*c -: 16]));
            v[c] = na * 65536 + (nb - na) * t;
            mag = (v[c] < 0) ? -v[c] : v[c];
            sum += mag * mag;
        end
        rem = sum;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        for (int c = 0; c < 3; c++)
        begin
            n[c] = 0;
            if (root != 0)
            begin
                mag = (v[c] < 0) ? -v[c] : v[c];
                q = (mag * kvm_pkg::NORM_ONE + root / 2) / root;
                if (q > kvm_pkg::NORM_ONE) q = kvm_pkg::NORM_ONE;
                n[c] = (v[c] < 0) ? -longint'(q) : longint'(q);
            end
        end
        r.pos_x  = pos[0][31:0];
        r.pos_y  = pos[1][31:0];
        r.pos_z  = pos[2][31:0];
        r.norm_x = n[0][15:0];
        r.norm_y = n[1][15:0];
        r.norm_z = n[2][15:0];
        return 1;
    endfunction

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic kvm_pkg::in_t noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(kvm_pkg::in_t)-1:0];
    endfunction

    task automatic send(kvm_pkg::in_t x);
        kvm_pkg::out_t e;
        int g;
        item <= x;
        push <= 1'b1;
        do @(posedge clk); while (full);
        if (morph_predict(x, e))
        begin
            sb.note(e);
            n_queries++;
        end
        else
            n_loads++;
        g = pick_gap();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic load_param(int f, int s, logic [31:0] val);
        kvm_pkg::in_t x;
        x = noise_item();
        x.mode = kvm_pkg::MODE_PARAM;
        x.frame_a = 8'(f);
        x.param_select = 3'(s);
        x.param_value = val;
        send(x);
    endtask

    task automatic load_vertex(int f, int vi, logic [31:0] packed_v);
        kvm_pkg::in_t x;
        x = noise_item();
        x.mode = kvm_pkg::MODE_VERTEX;
        x.frame_a = 8'(f);
        x.vertex_index = 11'(vi);
        {x.normal_code, x.byte_z, x.byte_y, x.byte_x} = packed_v;
        send(x);
    endtask

    // make sure everything a query reads has been loaded
    task automatic fill_frame(int f, int vi);
        int addr;
        for (int s = 0; s < kvm_pkg::PARAM_COUNT; s++)
            if (!frame_tab_set[f*kvm_pkg::PARAM_COUNT + s])
                load_param(f, s, $urandom);
        addr = f * live_verts() + vi;
        if (addr < kvm_pkg::VSTORE_DEPTH && !vert_mem_set[addr])
            load_vertex(f, vi, $urandom);
    endtask

    task automatic query(int fa, int fb, int vi, int t);
        kvm_pkg::in_t x;
        int nf;
        int cv;
        nf = live_frames();
        cv = (vi >= live_verts()) ? 0 : vi;
        fill_frame((fa >= nf) ? nf - 1 : fa, cv);
        fill_frame((fb >= nf) ? nf - 1 : fb, cv);
        x = noise_item();
        x.mode = kvm_pkg::MODE_QUERY;
        x.frame_a = 8'(fa);
        x.frame_b = 8'(fb);
        x.vertex_index = 11'(vi);
        x.blend = 17'(t);
        send(x);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [kvm_pkg::CFG_IDX_W-1:0] idx,
                             logic [kvm_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == kvm_pkg::CFG_FRAME_COUNT) frame_count_r = val[8:0];
        else if (idx == kvm_pkg::CFG_VERTS_PER_FRAME) verts_per_frame_r = val;
    endtask

    task automatic set_phase(int fc, int vpf);
        wait_idle();
        write_cfg(kvm_pkg::CFG_FRAME_COUNT, kvm_pkg::CFG_DATA_W'(fc));
        write_cfg(kvm_pkg::CFG_VERTS_PER_FRAME, kvm_pkg::CFG_DATA_W'(vpf));
        n_phases++;
    endtask

    task automatic directed_items();
        load_param(0, 0, 32'h7FFF_FFFF);
        load_param(0, 3, 32'h8000_0000);
        load_param(1, 0, 32'h8000_0000);
        load_param(1, 3, 32'h7FFF_FFFF);
        load_vertex(0, 0, {8'd5, 8'd255, 8'd0, 8'd255});
        load_vertex(1, 0, {8'd84, 8'd0, 8'd255, 8'd255});
        load_vertex(2, 7, {8'd161, 8'd255, 8'd255, 8'd0});
        load_vertex(3, 7, {8'd255, 8'd1, 8'd128, 8'd77});
        query(0, 1, 0, 0);
        query(0, 1, 0, kvm_pkg::BLEND_ONE);
        query(0, 1, 0, 32768);
        query(0, 1, 0, 131071);
        query(2, 3, 7, 12345);
        query(200, 255, 7, 40000);
        query(2, 3, 2000, 65535);
        load_param(2, 6, 32'h1234_5678);
        load_param(2, 7, 32'hFFFF_FFFF);
        load_vertex(2, 9, 32'hFFFF_FFFF);
        begin
            kvm_pkg::in_t x;
            x = noise_item();
            x.mode = MODE_NONE;
            send(x);
        end
        query(2, 3, 7, 1);
        query(3, 2, 7, kvm_pkg::BLEND_ONE + 1);
    endtask

    task automatic random_items(int count);
        kvm_pkg::in_t x;
        int nf;
        int nv;
        int r;
        nf = live_frames();
        nv = live_verts();
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                query((r < 45) ? $urandom_range(nf - 1) : $urandom_range(255),
                      (r < 40) ? $urandom_range(nf - 1) : $urandom_range(255),
                      (r < 42) ? $urandom_range(nv - 1) : $urandom_range(2047),
                      (r < 47) ? $urandom_range(kvm_pkg::BLEND_ONE) : $urandom_range(131071));
            else if (r < 72)
                load_vertex((r < 68) ? $urandom_range(nf - 1) : $urandom_range(255),
                            (r < 69) ? $urandom_range(nv - 1) : $urandom_range(2047),
                            $urandom);
            else if (r < 92)
                load_param($urandom_range(nf - 1), $urandom_range(5), $urandom);
            else
            begin
                x = noise_item();
                if (x.mode == kvm_pkg::MODE_QUERY)
                    x.mode = MODE_NONE;
                send(x);
            end
        end
    endtask

    // result side
    int hold_left;
    int pop_gap;
    initial
    begin
        hold_left = 0;
        pop_gap = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) sb.check(result);
            if (hold_request)
            begin
                hold_request = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop_gap = pick_gap();
                pop <= (pop_gap == 0);
            end
        end
    end

    int idle_cycles;
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (rst_n)
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        n_queries = 0;
        n_loads = 0;
        n_phases = 0;
        hold_request = 0;
        frame_count_r = 1;
        verts_per_frame_r = 1;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_items(40);
        set_phase(4, 8);
        directed_items();
        hold_request = 1;
        random_items(100);
        set_phase(0, 0);
        random_items(60);
        set_phase(511, 4095);
        random_items(16);
        set_phase(256, 2048);
        random_items(16);
        set_phase(3, 5);
        random_items(60);
        set_phase(17, 30);
        random_items(60);
        wait_idle();

        $display("covered %0d configuration phases, %0d loads/ignored items, %0d queries",
                 n_phases, n_loads, n_queries);
        $display("%0d results checked, %0d mismatches", sb.matched, sb.errors);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
